### hdl/hpc_pkg.sv
package hpc_pkg;

   // Default configuration of the block
   localparam int TILE_LOG2_DEF        = 4;
   localparam int SUBPIX_BITS_DEF      = 6;
   localparam int MAX_REGION_TILES_DEF = 256;

   // Field widths
   localparam int COEF_W    = 32;
   localparam int CONST_W   = 64;
   localparam int COORD_W   = 12;
   localparam int COVER_W   = 8;
   localparam int REGION_W  = 9;

   // Request beat layout, lowest bit first
   localparam int EDGE_A_LSB     = 0;
   localparam int EDGE_B_LSB     = EDGE_A_LSB + COEF_W;
   localparam int EDGE_C_LSB     = EDGE_B_LSB + COEF_W;
   localparam int EDGE_SCALE_LSB = EDGE_C_LSB + CONST_W;
   localparam int PIXEL_X_LSB    = EDGE_SCALE_LSB + COEF_W;
   localparam int PIXEL_Y_LSB    = PIXEL_X_LSB + COORD_W;
   localparam int REQ_DATA_W     = PIXEL_Y_LSB + COORD_W;
   localparam int RSP_DATA_W     = COVER_W;

   // Register port
   localparam int CSR_ADDR_W = 1;
   localparam int CSR_DATA_W = REGION_W;
   localparam logic [CSR_ADDR_W-1:0] CSR_REGION_WIDTH  = 1'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_REGION_HEIGHT = 1'd1;

   localparam logic [COVER_W-1:0] COVER_NONE = 8'h00;
   localparam logic [COVER_W-1:0] COVER_FULL = 8'hFF;

endpackage

### hdl/halfplane_coverage_tiles_top.sv
// Channel   | Dir | Signals                                  | Beat fields
// ----------+-----+------------------------------------------+-----------------------------
// request   | in  | req_tvalid, req_tready, req_tdata[183:0] | edge_a, edge_b, edge_c,
//           |     |                                          | edge_scale, pixel_x, pixel_y
// response  | out | rsp_tvalid, rsp_tready, rsp_tdata[7:0]   | coverage
// registers | in  | csr_we, csr_addr[0:0], csr_wdata[8:0]    | region_width_tiles,
//           |     |                                          | region_height_tiles
//
// One beat per clock in and out while the response side does not stall; seven register
// stages, through which each accepted request beat moves in order to the output register.
// Each stage holds about one 32x32 multiply or one 64-bit add/compare (clock period only).
// Synchronous reset empties the pipeline and sets both region registers to one tile.
// A stall on the response side freezes every stage at once; req_tready then drops in the
// same cycle, so no beat is lost or repeated.
module halfplane_coverage_tiles_top #(
   parameter int TILE_LOG2        = hpc_pkg::TILE_LOG2_DEF,
   parameter int SUBPIX_BITS      = hpc_pkg::SUBPIX_BITS_DEF,
   parameter int MAX_REGION_TILES = hpc_pkg::MAX_REGION_TILES_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   // request: edge_a[31:0], edge_b[63:32], edge_c[127:64], edge_scale[159:128],
   //          pixel_x[171:160], pixel_y[183:172]
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [hpc_pkg::REQ_DATA_W-1:0]    req_tdata,
   // response: coverage[7:0]
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [hpc_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   // register writes
   input  logic                              csr_we,
   input  logic [hpc_pkg::CSR_ADDR_W-1:0]    csr_addr,
   input  logic [hpc_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import hpc_pkg::*;

   // Derived fixed-point orders
   localparam int RES_ORD   = TILE_LOG2 + 2;
   localparam int MAX_ORD   = TILE_LOG2 + 1;
   localparam int TILE_SH   = SUBPIX_BITS + TILE_LOG2;    // tile offset of c
   localparam int C_SH      = SUBPIX_BITS + MAX_ORD;      // pre-shift of c before scaling
   localparam int S_AB      = RES_ORD + 44;
   localparam int S_C       = RES_ORD - MAX_ORD + 44;
   localparam int OUT_SH    = 9 - RES_ORD;
   localparam int FULL      = (256 << (8 - RES_ORD)) - 1;
   localparam int TI_W      = COORD_W - TILE_LOG2;
   localparam int PA_W      = COEF_W + TI_W + 1;
   localparam int NSTAGE    = 7;

   localparam logic signed [63:0] RND_AB  = 64'sd1 <<< (S_AB - 1);
   localparam logic signed [63:0] RND_C   = 64'sd1 <<< (S_C - 1);
   localparam logic [15:0]        BIAS_16 = 16'(1 << (15 - RES_ORD));
   localparam logic [15:0]        FULL_16 = 16'(FULL);
   localparam logic [REGION_W-1:0] MAX_TILES = REGION_W'(MAX_REGION_TILES);

   // Stage 1: captured beat, tile position, raw products
   typedef struct packed {
      logic [31:0]           a;
      logic [31:0]           b;
      logic [63:0]           c;
      logic [31:0]           scale;
      logic [TILE_LOG2-1:0]  lx;
      logic [TILE_LOG2-1:0]  ly;
      logic                  outside;
      logic                  single;
      logic [PA_W-1:0]       pa;
      logic [PA_W-1:0]       pb;
      logic [63:0]           paa;
      logic [63:0]           pbb;
   } s1_type;

   // Stage 2: tile sum, scaled a and b, tile extent
   typedef struct packed {
      logic [63:0]           c;
      logic [31:0]           scale;
      logic [TILE_LOG2-1:0]  lx;
      logic [TILE_LOG2-1:0]  ly;
      logic                  outside;
      logic                  single;
      logic [63:0]           t;
      logic [15:0]           aa;
      logic [15:0]           bb;
      logic [63:0]           offs;
      logic [63:0]           size;
   } s2_type;

   // Stage 3: c moved to the tile, per-tile setup
   typedef struct packed {
      logic [63:0] c_sel;
      logic [31:0] scale;
      logic        outside;
      logic        single;
      logic [63:0] offs;
      logic [63:0] size;
      logic [15:0] half;
      logic [15:0] delta;
      logic [15:0] lbb;
      logic [15:0] ax;
   } s3_type;

   // Stage 4: scaled c product, distance to the tile centre, ramp offsets
   typedef struct packed {
      logic [63:0] pcc;
      logic [63:0] d;
      logic        lt;
      logic [63:0] size;
      logic [15:0] half;
      logic [15:0] lbb;
      logic [15:0] v1;
      logic [15:0] v2;
      logic        outside;
      logic        single;
   } s4_type;

   typedef struct packed {
      logic [15:0] cc16;
      logic [63:0] absd;
      logic [63:0] size;
      logic        lt;
      logic [15:0] half;
      logic [15:0] lbb;
      logic [15:0] v1;
      logic [15:0] v2;
      logic        outside;
      logic        single;
   } s5_type;

   typedef struct packed {
      logic [15:0] ccf;
      logic        edge_hit;
      logic        lt;
      logic [15:0] v1;
      logic [15:0] v2;
      logic        outside;
      logic        single;
   } s6_type;

   logic [REGION_W-1:0] region_width_ff, region_width_in;
   logic [REGION_W-1:0] region_height_ff, region_height_in;
   logic [NSTAGE-1:0]   valid_ff, valid_in;
   logic                advance;

   s1_type s1_ff, s1_in;
   s2_type s2_ff, s2_in;
   s3_type s3_ff, s3_in;
   s4_type s4_ff, s4_in;
   s5_type s5_ff, s5_in;
   s6_type s6_ff, s6_in;
   logic [COVER_W-1:0] coverage_ff, coverage_in;

   // The whole pipe moves when the output register is free or being emptied
   assign advance    = !valid_ff[NSTAGE-1] || rsp_tready;
   assign req_tready = advance;
   assign rsp_tvalid = valid_ff[NSTAGE-1];
   assign rsp_tdata  = coverage_ff;
   assign valid_in   = {valid_ff[NSTAGE-2:0], req_tvalid};

   // ---------------------------------------------------------------- registers
   always_comb begin
      region_width_in  = region_width_ff;
      region_height_in = region_height_ff;
      if (csr_we) begin
         unique case (csr_addr)
            CSR_REGION_WIDTH:  region_width_in  = csr_wdata;
            CSR_REGION_HEIGHT: region_height_in = csr_wdata;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         region_width_ff  <= REGION_W'(1);
         region_height_ff <= REGION_W'(1);
      end else begin
         region_width_ff  <= region_width_in;
         region_height_ff <= region_height_in;
      end
   end

   // ---------------------------------------------------------------- stage 1
   logic [REGION_W-1:0] w_sat, h_sat;
   logic [COORD_W-1:0]  px, py;
   logic [TI_W-1:0]     ti, tj;

   always_comb begin
      // Clip oversized regions to the supported tile count
      w_sat = (region_width_ff  > MAX_TILES) ? MAX_TILES : region_width_ff;
      h_sat = (region_height_ff > MAX_TILES) ? MAX_TILES : region_height_ff;
      px    = req_tdata[PIXEL_X_LSB +: COORD_W];
      py    = req_tdata[PIXEL_Y_LSB +: COORD_W];
      ti    = px[COORD_W-1:TILE_LOG2];
      tj    = py[COORD_W-1:TILE_LOG2];

      s1_in.a       = req_tdata[EDGE_A_LSB +: COEF_W];
      s1_in.b       = req_tdata[EDGE_B_LSB +: COEF_W];
      s1_in.c       = req_tdata[EDGE_C_LSB +: CONST_W];
      s1_in.scale   = req_tdata[EDGE_SCALE_LSB +: COEF_W];
      s1_in.lx      = px[TILE_LOG2-1:0];
      s1_in.ly      = py[TILE_LOG2-1:0];
      s1_in.outside = (COORD_W'(ti) >= COORD_W'(w_sat)) || (COORD_W'(tj) >= COORD_W'(h_sat));
      s1_in.single  = (w_sat == REGION_W'(1)) && (h_sat == REGION_W'(1));
      s1_in.pa      = PA_W'($signed(s1_in.a)) * PA_W'($signed({1'b0, ti}));
      s1_in.pb      = PA_W'($signed(s1_in.b)) * PA_W'($signed({1'b0, tj}));
      s1_in.paa     = 64'($signed(s1_in.a)) * 64'($signed(s1_in.scale));
      s1_in.pbb     = 64'($signed(s1_in.b)) * 64'($signed(s1_in.scale));
   end

   // ---------------------------------------------------------------- stage 2
   logic signed [63:0] aa_rnd, bb_rnd;
   logic signed [32:0] ab_sum;
   logic [31:0]        abs_a, abs_b, abs_sum;

   always_comb begin
      // Round half up, then keep the low 16 bits
      aa_rnd  = ($signed(s1_ff.paa) + RND_AB) >>> S_AB;
      bb_rnd  = ($signed(s1_ff.pbb) + RND_AB) >>> S_AB;
      ab_sum  = 33'($signed(s1_ff.a)) + 33'($signed(s1_ff.b));
      abs_a   = s1_ff.a[31] ? 32'(0) - s1_ff.a : s1_ff.a;
      abs_b   = s1_ff.b[31] ? 32'(0) - s1_ff.b : s1_ff.b;
      abs_sum = abs_a + abs_b;

      s2_in.c       = s1_ff.c;
      s2_in.scale   = s1_ff.scale;
      s2_in.lx      = s1_ff.lx;
      s2_in.ly      = s1_ff.ly;
      s2_in.outside = s1_ff.outside;
      s2_in.single  = s1_ff.single;
      s2_in.t       = 64'($signed(s1_ff.pa)) + 64'($signed(s1_ff.pb));
      s2_in.aa      = aa_rnd[15:0];
      s2_in.bb      = bb_rnd[15:0];
      s2_in.offs    = 64'(ab_sum) << (TILE_SH - 1);
      s2_in.size    = 64'(abs_sum) << (TILE_SH - 1);
   end

   // ---------------------------------------------------------------- stage 3
   logic [63:0]        c_tile;
   logic [15:0]        hsum, abs_aa, abs_bb, min_ab;
   logic signed [17:0] delta_rnd;

   always_comb begin
      c_tile = s2_ff.c - (s2_ff.t << TILE_SH);
      hsum   = s2_ff.aa + s2_ff.bb;
      // Absolute value wraps: the most negative code maps to itself
      abs_aa = s2_ff.aa[15] ? 16'(0) - s2_ff.aa : s2_ff.aa;
      abs_bb = s2_ff.bb[15] ? 16'(0) - s2_ff.bb : s2_ff.bb;
      min_ab = ($signed(abs_bb) < $signed(abs_aa)) ? abs_bb : abs_aa;
      delta_rnd = (18'($signed(min_ab)) + 18'sd2) >>> 2;

      s3_in.c_sel   = s2_ff.single ? s2_ff.c : c_tile;
      s3_in.scale   = s2_ff.scale;
      s3_in.outside = s2_ff.outside;
      s3_in.single  = s2_ff.single;
      s3_in.offs    = s2_ff.offs;
      s3_in.size    = s2_ff.size;
      s3_in.half    = 16'($signed(hsum) >>> 1);
      s3_in.delta   = delta_rnd[15:0];
      s3_in.lbb     = 16'(s2_ff.ly) * s2_ff.bb;
      s3_in.ax      = 16'(s2_ff.lx) * s2_ff.aa;
   end

   // ---------------------------------------------------------------- stage 4
   logic [31:0] c32;

   always_comb begin
      c32 = s3_ff.c_sel[C_SH +: 32];

      s4_in.pcc     = 64'($signed(c32)) * 64'($signed(s3_ff.scale));
      s4_in.d       = s3_ff.offs - s3_ff.c_sel;
      s4_in.lt      = $signed(s3_ff.offs) < $signed(s3_ff.c_sel);
      s4_in.size    = s3_ff.size;
      s4_in.half    = s3_ff.half;
      s4_in.lbb     = s3_ff.lbb;
      s4_in.v1      = s3_ff.ax - s3_ff.delta;
      s4_in.v2      = s3_ff.ax + s3_ff.delta;
      s4_in.outside = s3_ff.outside;
      s4_in.single  = s3_ff.single;
   end

   // ---------------------------------------------------------------- stage 5
   logic signed [63:0] cc_rnd;

   always_comb begin
      cc_rnd = ($signed(s4_ff.pcc) + RND_C) >>> S_C;

      s5_in.cc16    = cc_rnd[15:0];
      s5_in.absd    = s4_ff.d[63] ? 64'(0) - s4_ff.d : s4_ff.d;
      s5_in.size    = s4_ff.size;
      s5_in.lt      = s4_ff.lt;
      s5_in.half    = s4_ff.half;
      s5_in.lbb     = s4_ff.lbb;
      s5_in.v1      = s4_ff.v1;
      s5_in.v2      = s4_ff.v2;
      s5_in.outside = s4_ff.outside;
      s5_in.single  = s4_ff.single;
   end

   // ---------------------------------------------------------------- stage 6
   always_comb begin
      // Row constant for this pixel, wrapping at 16 bits
      s6_in.ccf      = s5_ff.cc16 + BIAS_16 - s5_ff.half - s5_ff.lbb;
      s6_in.edge_hit = $signed(s5_ff.absd) < $signed(s5_ff.size);
      s6_in.lt       = s5_ff.lt;
      s6_in.v1       = s5_ff.v1;
      s6_in.v2       = s5_ff.v2;
      s6_in.outside  = s5_ff.outside;
      s6_in.single   = s5_ff.single;
   end

   // ---------------------------------------------------------------- stage 7
   logic [15:0]        ramp1, ramp2, clip1, clip2;
   logic [16:0]        ramp_sum;
   logic [COVER_W-1:0] tile_cov;

   always_comb begin
      ramp1 = s6_ff.ccf - s6_ff.v1;
      ramp2 = s6_ff.ccf - s6_ff.v2;
      clip1 = ramp1[15] ? 16'(0) : ((ramp1 > FULL_16) ? FULL_16 : ramp1);
      clip2 = ramp2[15] ? 16'(0) : ((ramp2 > FULL_16) ? FULL_16 : ramp2);
      ramp_sum = 17'(clip1) + 17'(clip2);
      tile_cov = COVER_W'(ramp_sum >> OUT_SH);

      priority if (s6_ff.outside)
         coverage_in = COVER_NONE;
      else if (s6_ff.single || s6_ff.edge_hit)
         coverage_in = tile_cov;
      else if (s6_ff.lt)
         coverage_in = COVER_FULL;
      else
         coverage_in = COVER_NONE;
   end

   // ---------------------------------------------------------------- pipe registers
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (advance) begin
         valid_ff <= valid_in;
      end
   end

   // Payload needs no reset; hold everything while stalled
   always_ff @(posedge clock) begin
      if (advance) begin
         s1_ff       <= s1_in;
         s2_ff       <= s2_in;
         s3_ff       <= s3_in;
         s4_ff       <= s4_in;
         s5_ff       <= s5_in;
         s6_ff       <= s6_in;
         coverage_ff <= coverage_in;
      end
   end

   // ---------------------------------------------------------------- assertions
   a_stall_blocks_input: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |-> !req_tready)
      else $error("request taken while response stalled");

   a_accept_enters_pipe: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> valid_ff[0])
      else $error("accepted beat missing from first stage");

   a_outside_is_zero: assert property (@(posedge clock) disable iff (reset)
      (valid_ff[NSTAGE-2] && advance && s6_ff.outside) |=> (rsp_tdata == COVER_NONE))
      else $error("pixel outside region gave nonzero coverage");

   a_inner_tile_full: assert property (@(posedge clock) disable iff (reset)
      (valid_ff[NSTAGE-2] && advance && !s6_ff.outside && !s6_ff.single
       && !s6_ff.edge_hit && s6_ff.lt) |=> (rsp_tdata == COVER_FULL))
      else $error("fully covered tile not reported as full");

endmodule
